// ===== sv/look_at_rotation_matrix_defines.svh =====
// Assertion shorthands used by the top-level RTL.
`ifndef LOOK_AT_ROTATION_MATRIX_DEFINES_SVH
`define LOOK_AT_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lar_pkg.sv =====
`timescale 1ns / 1ps

package lar_pkg;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 16;
  localparam int NORM_W = 30;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  typedef struct packed {
    logic signed [IN_W-1:0] eye_x;
    logic signed [IN_W-1:0] eye_y;
    logic signed [IN_W-1:0] eye_z;
    logic signed [IN_W-1:0] target_x;
    logic signed [IN_W-1:0] target_y;
    logic signed [IN_W-1:0] target_z;
    logic signed [IN_W-1:0] upref_x;
    logic signed [IN_W-1:0] upref_y;
    logic signed [IN_W-1:0] upref_z;
  } lar_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] trueup_x;
    logic signed [OUT_W-1:0] trueup_y;
    logic signed [OUT_W-1:0] trueup_z;
    logic signed [OUT_W-1:0] forward_x;
    logic signed [OUT_W-1:0] forward_y;
    logic signed [OUT_W-1:0] forward_z;
    logic                    degenerate;
  } lar_out_t;

endpackage

// ===== sv/lar_delay.sv =====
`timescale 1ns / 1ps

module lar_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ===== sv/lar_cross.sv =====
`timescale 1ns / 1ps

module lar_cross #(
  parameter int CW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2:0][CW-1:0]    a_i,
  input  logic [2:0][CW-1:0]    b_i,
  output logic                  valid_o,
  output logic [2:0][2*CW:0]    c_o
);

  localparam int PW = 2 * CW;
  localparam int XW = 2 * CW + 1;

  logic signed [PW-1:0] p_q [6];
  logic signed [XW-1:0] c_q [3];
  logic                 p_vld_q, c_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      p_vld_q <= valid_i;
      c_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= $signed(a_i[1]) * $signed(b_i[2]);
    p_q[1] <= $signed(a_i[2]) * $signed(b_i[1]);
    p_q[2] <= $signed(a_i[2]) * $signed(b_i[0]);
    p_q[3] <= $signed(a_i[0]) * $signed(b_i[2]);
    p_q[4] <= $signed(a_i[0]) * $signed(b_i[1]);
    p_q[5] <= $signed(a_i[1]) * $signed(b_i[0]);
    c_q[0] <= p_q[0] - p_q[1];
    c_q[1] <= p_q[2] - p_q[3];
    c_q[2] <= p_q[4] - p_q[5];
  end

  assign valid_o = c_vld_q;
  assign c_o[0]  = c_q[0];
  assign c_o[1]  = c_q[1];
  assign c_o[2]  = c_q[2];

endmodule

// ===== sv/lar_unitize.sv =====
`timescale 1ns / 1ps

module lar_unitize #(
  parameter int IN_W = 33,
  parameter int FRAC = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2:0][IN_W-1:0]  vec_i,
  output logic                  valid_o,
  output logic                  ok_o,
  output logic [2:0][FRAC+1:0]  vec_o
);

  localparam int NW   = lar_pkg::NORM_W;
  localparam int SW   = 2 * NW + 2;
  localparam int RW   = NW + 1;
  localparam int REMW = RW + 2;
  localparam int SQN  = RW;
  localparam int QB   = FRAC + 1;
  localparam int CW   = FRAC + 2;
  localparam int LW   = $clog2(IN_W + 1);
  localparam int NUMW = NW + FRAC + 1;

  typedef struct packed {
    logic [2:0][NW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } car_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
    logic [SW-1:0]   s;
    car_t            c;
  } sqs_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QB-1:0] lq;
    logic [RW-1:0]      l;
    logic [2:0]         neg;
    logic               zero;
  } dvs_t;

  function automatic sqs_t sqrt_step(input sqs_t x);
    sqs_t          y;
    logic [REMW+1:0] t;
    logic [REMW+1:0] trial;
    y     = x;
    t     = {x.rem, x.s[SW-1:SW-2]};
    trial = (REMW+2)'({x.root, 2'b01});
    if (t >= trial) begin
      y.rem  = REMW'(t - trial);
      y.root = {x.root[RW-2:0], 1'b1};
    end else begin
      y.rem  = t[REMW-1:0];
      y.root = {x.root[RW-2:0], 1'b0};
    end
    y.s = {x.s[SW-3:0], 2'b00};
    return y;
  endfunction

  function automatic dvs_t div_init(input sqs_t x);
    dvs_t          y;
    logic [NUMW-1:0] num;
    y.l    = x.root;
    y.neg  = x.c.neg;
    y.zero = x.c.zero;
    for (int i = 0; i < 3; i++) begin
      num      = NUMW'({x.c.mag[i], FRAC'(0)}) + NUMW'(x.root >> 1);
      y.rem[i] = RW'(num[NUMW-1:QB]);
      y.lq[i]  = num[QB-1:0];
    end
    return y;
  endfunction

  function automatic dvs_t div_step(input dvs_t x);
    dvs_t        y;
    logic [RW:0] r2;
    logic        qbit;
    y = x;
    for (int i = 0; i < 3; i++) begin
      r2 = {x.rem[i], x.lq[i][QB-1]};
      if (r2 >= {1'b0, x.l}) begin
        y.rem[i] = RW'(r2 - {1'b0, x.l});
        qbit     = 1'b1;
      end else begin
        y.rem[i] = r2[RW-1:0];
        qbit     = 1'b0;
      end
      y.lq[i] = {x.lq[i][QB-2:0], qbit};
    end
    return y;
  endfunction

  // abs and max
  logic [2:0][IN_W-1:0] mag_d;
  logic [2:0]           neg_d;
  logic [IN_W-1:0]      max_d;
  logic [2:0][IN_W-1:0] s1_mag_q;
  logic [2:0]           s1_neg_q;
  logic [IN_W-1:0]      s1_max_q;

  // leading one
  logic [LW-1:0]        len_d;
  logic [LW-1:0]        s2_len_q;
  logic [2:0][IN_W-1:0] s2_mag_q;
  logic [2:0]           s2_neg_q;

  // normalize, square
  car_t                 s3_d;
  car_t                 s3_q;
  car_t                 s4_q;
  logic [2:0][SW-1:0]   s4_sq_q;

  sqs_t                 sqs_q [SQN+1];
  dvs_t                 dv_q  [QB+1];
  logic [2:0][CW-1:0]   out_q;
  logic                 ok_q;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic [SQN:0]         sq_vld_q;
  logic [QB:0]          dv_vld_q;

  always_comb begin
    max_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][IN_W-1];
      mag_d[i] = neg_d[i] ? (~vec_i[i]) + IN_W'(1) : vec_i[i];
      if (mag_d[i] > max_d) max_d = mag_d[i];
    end
  end

  always_comb begin
    len_d = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (s1_max_q[i]) len_d = LW'(i + 1);
    end
  end

  always_comb begin
    logic [IN_W+NW-1:0] w;
    for (int i = 0; i < 3; i++) begin
      w            = {s2_mag_q[i], NW'(0)} >> s2_len_q;
      s3_d.mag[i]  = w[NW-1:0];
    end
    s3_d.neg  = s2_neg_q;
    s3_d.zero = (s2_len_q == '0);
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q <= mag_d;
    s1_neg_q <= neg_d;
    s1_max_q <= max_d;
    s2_len_q <= len_d;
    s2_mag_q <= s1_mag_q;
    s2_neg_q <= s1_neg_q;
    s3_q     <= s3_d;
    s4_q     <= s3_q;
    for (int i = 0; i < 3; i++) begin
      s4_sq_q[i] <= SW'(s3_q.mag[i] * s3_q.mag[i]);
    end
    sqs_q[0].rem  <= '0;
    sqs_q[0].root <= '0;
    sqs_q[0].s    <= s4_sq_q[0] + s4_sq_q[1] + s4_sq_q[2];
    sqs_q[0].c    <= s4_q;
    for (int k = 0; k < SQN; k++) begin
      sqs_q[k+1] <= sqrt_step(sqs_q[k]);
    end
    dv_q[0] <= div_init(sqs_q[SQN]);
    for (int k = 0; k < QB; k++) begin
      dv_q[k+1] <= div_step(dv_q[k]);
    end
    for (int i = 0; i < 3; i++) begin
      out_q[i] <= dv_q[QB].neg[i] ? CW'(0) - CW'(dv_q[QB].lq[i]) : CW'(dv_q[QB].lq[i]);
    end
    ok_q <= !dv_q[QB].zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      sq_vld_q  <= {sq_vld_q[SQN-1:0], s4_vld_q};
      dv_vld_q  <= {dv_vld_q[QB-1:0], sq_vld_q[SQN]};
      out_vld_q <= dv_vld_q[QB];
    end
  end

  assign valid_o = out_vld_q;
  assign ok_o    = ok_q;
  assign vec_o   = out_q;

endmodule

// ===== sv/look_at_rotation_matrix.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// -------   ------------------   ---------------------------
// input     start / busy         data_i   (lar_pkg::lar_in_t)
// result    done_o strobe        result_o (lar_pkg::lar_out_t)
//
// One transfer per cycle; busy stays low, nothing inside ever stalls.
// Four normalizers, the forward and up ones side by side, then right, then true-up;
// each is a 31-step root pipeline plus an OUT_FRAC_BITS+1 step divider.
// Reset clears only the valid bits; results are not held, done_o pulses once.

`include "look_at_rotation_matrix_defines.svh"

module look_at_rotation_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  lar_pkg::lar_in_t   data_i,
  output logic               busy,
  output logic               done_o,
  output lar_pkg::lar_out_t  result_o
);

  localparam int F    = OUT_FRAC_BITS;
  localparam int CW   = F + 2;
  localparam int XW   = 2 * CW + 1;
  localparam int DW   = lar_pkg::IN_W + 1;
  localparam int UW   = lar_pkg::IN_W;
  localparam int ULAT = 39 + F;
  localparam int XLAT = 2;
  localparam int HOP  = XLAT + ULAT;
  localparam int LAT  = 3 * ULAT + 2 * XLAT + 2;
  localparam int EW   = (CW > 17) ? CW : 17;

  function automatic logic [lar_pkg::OUT_W-1:0] sat16(input logic [CW-1:0] c);
    logic signed [EW-1:0] e;
    e = EW'($signed(c));
    if (e > EW'(lar_pkg::OUT_MAX)) e = EW'(lar_pkg::OUT_MAX);
    if (e < EW'(lar_pkg::OUT_MIN)) e = EW'(lar_pkg::OUT_MIN);
    return e[lar_pkg::OUT_W-1:0];
  endfunction

  logic               in_vld_q;
  logic [2:0][DW-1:0] d_q;
  logic [2:0][UW-1:0] u_q;

  logic               fw_vld, up_vld, ok_fw, ok_up;
  logic [2:0][CW-1:0] fw, un, fw_d1, fw_d2;
  logic               x1_vld, x2_vld;
  logic [2:0][XW-1:0] r, t;
  logic               r_vld, ok_r, t_vld, ok_t;
  logic [2:0][CW-1:0] rn, rn_d, tn;
  logic               ok1_d, ok2_d, ok_all;

  lar_pkg::lar_out_t  res_d, res_q;
  logic               done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
      done_q   <= t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0] <= DW'(data_i.target_x) - DW'(data_i.eye_x);
    d_q[1] <= DW'(data_i.target_y) - DW'(data_i.eye_y);
    d_q[2] <= DW'(data_i.target_z) - DW'(data_i.eye_z);
    u_q[0] <= data_i.upref_x;
    u_q[1] <= data_i.upref_y;
    u_q[2] <= data_i.upref_z;
    res_q  <= res_d;
  end

  lar_unitize #(.IN_W(DW), .FRAC(F)) u_norm_fw (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .vec_i(d_q),
    .valid_o(fw_vld), .ok_o(ok_fw), .vec_o(fw)
  );

  lar_unitize #(.IN_W(UW), .FRAC(F)) u_norm_up (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .vec_i(u_q),
    .valid_o(up_vld), .ok_o(ok_up), .vec_o(un)
  );

  lar_cross #(.CW(CW)) u_cross_r (
    .clk_i, .rst_ni, .valid_i(fw_vld && up_vld), .a_i(un), .b_i(fw),
    .valid_o(x1_vld), .c_o(r)
  );

  lar_delay #(.W(1), .DEPTH(HOP)) u_dly_ok1 (
    .clk_i, .d_i(ok_fw && ok_up), .q_o(ok1_d)
  );

  lar_delay #(.W(3 * CW), .DEPTH(HOP)) u_dly_fw1 (
    .clk_i, .d_i(fw), .q_o(fw_d1)
  );

  lar_unitize #(.IN_W(XW), .FRAC(F)) u_norm_r (
    .clk_i, .rst_ni, .valid_i(x1_vld), .vec_i(r),
    .valid_o(r_vld), .ok_o(ok_r), .vec_o(rn)
  );

  lar_cross #(.CW(CW)) u_cross_t (
    .clk_i, .rst_ni, .valid_i(r_vld), .a_i(fw_d1), .b_i(rn),
    .valid_o(x2_vld), .c_o(t)
  );

  lar_delay #(.W(1), .DEPTH(HOP)) u_dly_ok2 (
    .clk_i, .d_i(ok1_d && ok_r), .q_o(ok2_d)
  );

  lar_delay #(.W(3 * CW), .DEPTH(HOP)) u_dly_fw2 (
    .clk_i, .d_i(fw_d1), .q_o(fw_d2)
  );

  lar_delay #(.W(3 * CW), .DEPTH(HOP)) u_dly_rn (
    .clk_i, .d_i(rn), .q_o(rn_d)
  );

  lar_unitize #(.IN_W(XW), .FRAC(F)) u_norm_t (
    .clk_i, .rst_ni, .valid_i(x2_vld), .vec_i(t),
    .valid_o(t_vld), .ok_o(ok_t), .vec_o(tn)
  );

  assign ok_all = ok2_d && ok_t;

  always_comb begin
    res_d = '0;
    if (ok_all) begin
      res_d.right_x   = sat16(rn_d[0]);
      res_d.right_y   = sat16(rn_d[1]);
      res_d.right_z   = sat16(rn_d[2]);
      res_d.trueup_x  = sat16(tn[0]);
      res_d.trueup_y  = sat16(tn[1]);
      res_d.trueup_z  = sat16(tn[2]);
      res_d.forward_x = sat16(fw_d2[0]);
      res_d.forward_y = sat16(fw_d2[1]);
      res_d.forward_z = sat16(fw_d2[2]);
    end else begin
      res_d.degenerate = 1'b1;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `LAR_ASSERT_NXT(a_accept_enters, start && !busy, in_vld_q, "accepted transfer not in pipe")
  `LAR_ASSERT_IMP(a_latency, done_o, $past(start && !busy, LAT), "result without matching transfer")
  `LAR_ASSERT_IMP(a_degen_zero, done_o && result_o.degenerate,
    (result_o.right_x == '0) && (result_o.trueup_y == '0) && (result_o.forward_z == '0),
    "degenerate result carries data")
  `LAR_ASSERT_IMP(a_fwd_nonzero, done_o && !result_o.degenerate,
    (result_o.forward_x != '0) || (result_o.forward_y != '0) || (result_o.forward_z != '0),
    "forward row is zero")

endmodule
